// File: rtl/pwmt_pkg.sv
// ----------------------------------------------------------------------------
// pwmt_pkg: shared types and constants of the post/wait match table
// Request and status codes, table sizing and the per-cell control bundle.
// ----------------------------------------------------------------------------
package pwmt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int NODE_W      = 16;
	localparam int TAG_W       = 32;
	localparam int TOTAL_W     = 6;

	typedef enum logic [1:0] {
		REQ_POST          = 2'd0,
		REQ_WAIT_ANY      = 2'd1,
		REQ_WAIT_NODE     = 2'd2,
		REQ_WAIT_NODE_TAG = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NO_MATCH = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE  = 1'b0,
		S_APPLY = 1'b1
	} state_t;

	typedef struct packed {
		logic cmp_en;    // capture a fresh match result
		logic use_tag;   // tag must match as well
		logic occupied;  // slot holds a live entry
		logic load;      // write the posted entry into this slot
		logic shift;     // take the entry of the upper neighbor
	} cell_ctl_t;

	typedef struct packed {
		req_type_t          kind;
		logic [NODE_W-1:0]  node;
		logic [TAG_W-1:0]   tag;
	} req_t;

	// OR of bit i and every bit above it, built by doubling spans
	function automatic logic [TABLE_DEPTH-1:0] suffix_or(input logic [TABLE_DEPTH-1:0] m);
		logic [TABLE_DEPTH-1:0] s;
		s = m;
		for (int k = 1; k < TABLE_DEPTH; k = k * 2) begin
			s = s | (s >> k);
		end
		return s;
	endfunction

endpackage

// File: rtl/post_wait_match_table_unit.sv
// ----------------------------------------------------------------------------
// post_wait_match_table_unit: ordered table of posted (node, tag) entries
// Post appends, the wait requests remove the newest (matching) entry and
// the entries above it move down one slot.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis stream, one request per transfer. Every
//   request returns one result transfer on m_axis: the status and the number
//   of entries held afterwards.
//   Each request passes a compare cycle and an update cycle: in the accept
//   cycle every cell of the slot chain compares its entry with the key; in
//   the update cycle the chain shifts or loads and the result is registered.
//   A new request is taken only once the previous one has finished this
//   compare-then-update pass; m_axis shows the registered result.
//   While a result waits on a stalled receiver, one more request is taken
//   and compared; its update then holds until the pending result leaves.
//   Reset empties the table (count zero) and drops any pending result; slot
//   contents are not cleared, only slots below the count are ever used.
//   A post to a full table is dropped and reports full.
// ----------------------------------------------------------------------------
module post_wait_match_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // req_type[1:0], node_id[17:2], tag_value[49:18]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // status[1:0], entry_total[7:2]
);
	import pwmt_pkg::*;

	state_t                  state_q, state_d;
	req_t                    req_q;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic                    out_valid_q;
	status_t                 out_status_q, status_d;
	logic [TOTAL_W-1:0]      out_total_q;

	logic                    in_fire, apply_go, post_ok, do_shift, any_match;
	req_type_t               in_kind;
	cell_ctl_t               ctl [TABLE_DEPTH];
	logic [NODE_W-1:0]       node_vec [TABLE_DEPTH];
	logic [TAG_W-1:0]        tag_vec  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  match_vec, above;

	assign in_kind  = req_type_t'(s_axis_tdata[1:0]);
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign any_match = |match_vec;
	assign above    = suffix_or(match_vec) >> 1;

	// request controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		apply_go      = 1'b0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				// hold the update while the previous result is still pending
				if (!out_valid_q || m_axis_tready) begin
					apply_go = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// request decode against the captured match results
	always_comb begin
		cnt_d    = cnt_q;
		status_d = ST_DONE;
		post_ok  = 1'b0;
		do_shift = 1'b0;
		unique case (req_q.kind) inside
			REQ_POST: begin
				if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					post_ok = 1'b1;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			REQ_WAIT_ANY: begin
				if (cnt_q == '0) begin
					status_d = ST_NO_MATCH;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			REQ_WAIT_NODE, REQ_WAIT_NODE_TAG: begin
				if (any_match) begin
					do_shift = 1'b1;
					cnt_d    = cnt_q - 1'b1;
				end else begin
					status_d = ST_NO_MATCH;
				end
			end
			default: status_d = ST_NO_MATCH;
		endcase
	end

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			ctl[i].cmp_en   = in_fire;
			ctl[i].use_tag  = (in_kind == REQ_WAIT_NODE_TAG);
			ctl[i].occupied = (CNT_W'(i) < cnt_q);
			ctl[i].load     = apply_go && post_ok && (cnt_q == CNT_W'(i));
			// slots from the removed one upward take their upper neighbor
			ctl[i].shift    = apply_go && do_shift && !above[i];
		end
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		logic [NODE_W-1:0] up_node;
		logic [TAG_W-1:0]  up_tag;
		if (g == TABLE_DEPTH - 1) begin : g_top
			assign up_node = '0;
			assign up_tag  = '0;
		end else begin : g_mid
			assign up_node = node_vec[g+1];
			assign up_tag  = tag_vec[g+1];
		end
		pwmt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[g]),
			.key_node   (s_axis_tdata[17:2]),
			.key_tag    (s_axis_tdata[49:18]),
			.load_node  (req_q.node),
			.load_tag   (req_q.tag),
			.upper_node (up_node),
			.upper_tag  (up_tag),
			.node       (node_vec[g]),
			.tag        (tag_vec[g]),
			.match      (match_vec[g])
		);
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q.kind <= in_kind;
			req_q.node <= s_axis_tdata[17:2];
			req_q.tag  <= s_axis_tdata[49:18];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (apply_go) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			out_status_q <= status_d;
			out_total_q  <= TOTAL_W'(cnt_d);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_total_q, out_status_q};

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_accept_to_apply: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_APPLY))
		else $error("accepted request did not reach the update cycle");

	a_post_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(apply_go && (req_q.kind == REQ_POST) && (cnt_q != CNT_W'(TABLE_DEPTH)))
		|=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("post did not grow the table by one");

	a_total_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_total_q == TOTAL_W'(cnt_q)))
		else $error("reported total differs from held count");

	a_one_removed: assert property (@(posedge clk) disable iff (!arst_n)
		(apply_go && do_shift) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("matched wait did not remove exactly one entry");

endmodule

// File: rtl/pwmt_cell.sv
// ----------------------------------------------------------------------------
// pwmt_cell: one slot of the match table
// Holds one (node, tag) entry, compares it against a wait key and loads,
// keeps or takes the entry of its upper neighbor.
// ----------------------------------------------------------------------------
module pwmt_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pwmt_pkg::cell_ctl_t       ctl,
	input  logic [pwmt_pkg::NODE_W-1:0] key_node,
	input  logic [pwmt_pkg::TAG_W-1:0]  key_tag,
	input  logic [pwmt_pkg::NODE_W-1:0] load_node,
	input  logic [pwmt_pkg::TAG_W-1:0]  load_tag,
	input  logic [pwmt_pkg::NODE_W-1:0] upper_node,
	input  logic [pwmt_pkg::TAG_W-1:0]  upper_tag,
	output logic [pwmt_pkg::NODE_W-1:0] node,
	output logic [pwmt_pkg::TAG_W-1:0]  tag,
	output logic                      match
);
	import pwmt_pkg::*;

	logic [NODE_W-1:0] node_q;
	logic [TAG_W-1:0]  tag_q;
	logic              match_q;
	logic              hit;

	assign hit = ctl.occupied && (node_q == key_node) && (!ctl.use_tag || (tag_q == key_tag));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			match_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			node_q <= load_node;
			tag_q  <= load_tag;
		end else if (ctl.shift) begin
			node_q <= upper_node;
			tag_q  <= upper_tag;
		end
	end

	assign node  = node_q;
	assign tag   = tag_q;
	assign match = match_q;

endmodule

// File: sim/post_wait_match_table_unit_tb.sv
// ----------------------------------------------------------------------------
// post_wait_match_table_unit_tb: self-checking bench of the post/wait table
// Drives post and wait requests on the request stream, keeps a shadow copy
// of the table to work out the status and entry count of every request, and
// checks each result transfer in order under random idling on both sides.
// ----------------------------------------------------------------------------
module post_wait_match_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pwmt_pkg::*;

	localparam int QUIET_LIMIT = 1000;

	typedef struct packed {
		status_t            status;
		logic [TOTAL_W-1:0] total;
	} outcome_t;

	typedef struct {
		req_type_t          kind;
		logic [NODE_W-1:0]  node;
		logic [TAG_W-1:0]   tag;
		int                 reps;
		bit                 typed;
		status_t            status;
		logic [TOTAL_W-1:0] total;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;   // req_type[1:0], node_id[17:2], tag_value[49:18]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // status[1:0], entry_total[7:2]

	// shadow copy of the table, slot 0 the oldest
	logic [NODE_W-1:0] shadow_node [TABLE_DEPTH];
	logic [TAG_W-1:0]  shadow_tag  [TABLE_DEPTH];
	int                shadow_count;

	outcome_t pending_outcomes [$];
	int       fail_count;
	int       quiet_cycles;
	int       tx_idle_pct;
	int       rx_idle_pct;

	// rows with more than one repetition take random node and tag values
	directed_row_t directed_rows [0:20] = '{
		'{REQ_WAIT_ANY,      16'h0000, 32'h0000_0000,  1, 1'b1, ST_NO_MATCH, 6'd0},
		'{REQ_WAIT_NODE,     16'hffff, 32'h0000_0000,  1, 1'b1, ST_NO_MATCH, 6'd0},
		'{REQ_WAIT_NODE_TAG, 16'h0000, 32'hffff_ffff,  1, 1'b1, ST_NO_MATCH, 6'd0},
		'{REQ_POST,          16'h0000, 32'h8000_0000,  1, 1'b1, ST_DONE,     6'd1},
		'{REQ_POST,          16'hffff, 32'h7fff_ffff,  1, 1'b1, ST_DONE,     6'd2},
		'{REQ_POST,          16'h0000, 32'hffff_ffff,  1, 1'b1, ST_DONE,     6'd3},
		'{REQ_POST,          16'hffff, 32'h0000_0000,  1, 1'b1, ST_DONE,     6'd4},
		'{REQ_WAIT_NODE_TAG, 16'hffff, 32'h8000_0000,  1, 1'b1, ST_NO_MATCH, 6'd4},
		'{REQ_WAIT_NODE,     16'h1234, 32'h0000_0000,  1, 1'b1, ST_NO_MATCH, 6'd4},
		'{REQ_WAIT_NODE_TAG, 16'h0000, 32'h8000_0000,  1, 1'b0, ST_DONE,     6'd0},
		'{REQ_WAIT_NODE,     16'hffff, 32'h0000_0000,  1, 1'b0, ST_DONE,     6'd0},
		'{REQ_WAIT_ANY,      16'hffff, 32'hffff_ffff,  1, 1'b0, ST_DONE,     6'd0},
		'{REQ_POST,          16'h0005, 32'h5555_5555,  1, 1'b0, ST_DONE,     6'd0},
		'{REQ_POST,          16'h0005, 32'haaaa_aaaa,  1, 1'b0, ST_DONE,     6'd0},
		'{REQ_POST,          16'h0005, 32'h5555_5555,  1, 1'b0, ST_DONE,     6'd0},
		'{REQ_WAIT_NODE_TAG, 16'h0005, 32'h5555_5555,  1, 1'b0, ST_DONE,     6'd0},
		'{REQ_WAIT_NODE,     16'h0005, 32'hffff_ffff,  1, 1'b0, ST_DONE,     6'd0},
		'{REQ_POST,          16'h0000, 32'h0000_0000, 30, 1'b0, ST_DONE,     6'd0},
		'{REQ_POST,          16'haaaa, 32'h1234_5678,  1, 1'b1, ST_FULL,     6'd32},
		'{REQ_WAIT_ANY,      16'h0000, 32'h0000_0000, 32, 1'b0, ST_DONE,     6'd0},
		'{REQ_WAIT_ANY,      16'h0000, 32'h0000_0000,  1, 1'b1, ST_NO_MATCH, 6'd0}
	};

	post_wait_match_table_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// update the shadow table with one request and return its outcome
	function automatic outcome_t apply_request(input req_type_t kind,
			input logic [NODE_W-1:0] node, input logic [TAG_W-1:0] tag);
		outcome_t res;
		int       hit;
		res.status = ST_DONE;
		hit = -1;
		case (kind)
			REQ_POST: begin
				if (shadow_count >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_node[shadow_count] = node;
					shadow_tag[shadow_count]  = tag;
					shadow_count++;
				end
			end
			REQ_WAIT_ANY: begin
				if (shadow_count > 0) shadow_count--;
				else res.status = ST_NO_MATCH;
			end
			default: begin
				// newest match wins: scan from the top
				for (int i = shadow_count - 1; i >= 0 && hit < 0; i--) begin
					if (shadow_node[i] == node &&
							(kind != REQ_WAIT_NODE_TAG || shadow_tag[i] == tag))
						hit = i;
				end
				if (hit < 0) begin
					res.status = ST_NO_MATCH;
				end else begin
					for (int i = hit + 1; i < shadow_count; i++) begin
						shadow_node[i-1] = shadow_node[i];
						shadow_tag[i-1]  = shadow_tag[i];
					end
					shadow_count--;
				end
			end
		endcase
		res.total = TOTAL_W'(shadow_count);
		return res;
	endfunction

	// one request transfer; the expected outcome is queued on acceptance
	task automatic send_request(input req_type_t kind, input logic [NODE_W-1:0] node,
			input logic [TAG_W-1:0] tag, input bit use_typed, input outcome_t typed);
		outcome_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, tag, node, kind};
		do @(posedge clk); while (!s_axis_tready);
		predicted = apply_request(kind, node, tag);
		pending_outcomes.push_back(use_typed ? typed : predicted);
	endtask

	// bursts that fill, drain or mix, with matches drawn from live entries
	task automatic run_random(input int count);
		int                done;
		int                burst;
		int                mode;
		int                post_pct;
		int                idx;
		req_type_t         kind;
		logic [NODE_W-1:0] node;
		logic [TAG_W-1:0]  tag;
		done = 0;
		while (done < count) begin
			mode  = $urandom_range(2);
			burst = $urandom_range(48, 8);
			case (mode)
				0:       post_pct = 70;
				1:       post_pct = 25;
				default: post_pct = 40;
			endcase
			for (int b = 0; b < burst && done < count; b++) begin
				if ($urandom_range(9) == 0) begin
					kind = req_type_t'($urandom_range(3));
					node = NODE_W'($urandom);
					tag  = TAG_W'($urandom);
				end else begin
					kind = ($urandom_range(99) < post_pct) ? REQ_POST
						: req_type_t'($urandom_range(3, 1));
					if (kind != REQ_POST && shadow_count > 0 && $urandom_range(9) < 6) begin
						idx  = $urandom_range(shadow_count - 1);
						node = shadow_node[idx];
						tag  = ($urandom_range(3) != 0) ? shadow_tag[idx]
							: shadow_tag[idx] ^ (TAG_W'(1) << $urandom_range(TAG_W - 1));
					end else begin
						node = $urandom_range(1) ? NODE_W'($urandom_range(3)) : NODE_W'($urandom);
						case ($urandom_range(3))
							0:       tag = TAG_W'($urandom_range(3));
							1:       tag = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
							default: tag = TAG_W'($urandom);
						endcase
					end
				end
				send_request(kind, node, tag, 1'b0, '0);
				done++;
			end
		end
	endtask

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outcomes.size() == 0) begin
				$error("unexpected result: status %0d entry_total %0d",
					m_axis_tdata[1:0], m_axis_tdata[7:2]);
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (m_axis_tdata[1:0] !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_axis_tdata[1:0]);
					fail_count++;
				end
				if (m_axis_tdata[7:2] !== want.total) begin
					$error("entry_total: expected %0d, actual %0d", want.total,
						m_axis_tdata[7:2]);
					fail_count++;
				end
			end
		end
	end

	// end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("post_wait_match_table_unit_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		directed_row_t     row;
		outcome_t          typed;
		logic [NODE_W-1:0] node;
		logic [TAG_W-1:0]  tag;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		fail_count    = 0;
		shadow_count  = 0;
		tx_idle_pct   = 23;
		rx_idle_pct   = 56;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			row          = directed_rows[r];
			typed.status = row.status;
			typed.total  = row.total;
			for (int k = 0; k < row.reps; k++) begin
				node = row.node;
				tag  = row.tag;
				if (row.reps > 1) begin
					node = NODE_W'($urandom);
					tag  = TAG_W'($urandom);
				end
				send_request(row.kind, node, tag, row.typed, typed);
			end
		end

		run_random(600);
		tx_idle_pct = 56;
		rx_idle_pct = 23;
		run_random(585);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(585);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0) begin
			$display("post_wait_match_table_unit_tb passed");
		end else begin
			$display("post_wait_match_table_unit_tb failed");
		end
		$finish;
	end

endmodule
